// ----- hw/rtl/hsvrm_pkg.sv -----
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package hsvrm_pkg;

   // Forward window length in pixels (1..8).
   localparam int WINDOW = 3;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;

   // Configuration register codes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_HIGH = 3'd5;

   localparam logic [CH_W-1:0] HUE_LOW_RST  = 8'd0;
   localparam logic [CH_W-1:0] HUE_HIGH_RST = 8'd10;
   localparam logic [CH_W-1:0] SAT_LOW_RST  = 8'd43;
   localparam logic [CH_W-1:0] SAT_HIGH_RST = 8'd255;
   localparam logic [CH_W-1:0] VAL_LOW_RST  = 8'd46;
   localparam logic [CH_W-1:0] VAL_HIGH_RST = 8'd255;

   // Divider geometry: numerators stay below 2^18, divisors below 2^9,
   // and both quotients below 2^9.
   localparam int DIV_NUM_W  = 18;
   localparam int DIV_DEN_W  = 9;
   localparam int DIV_Q_W    = 9;
   localparam int DIV_STEP_W = $clog2(DIV_Q_W);

   localparam logic [DIV_Q_W-1:0] HUE_WRAP = 9'd180;

   typedef struct packed {
      logic             capture;
      logic             prep;
      logic             div_go;
      logic             div_hue;
      logic             s_latch;
      logic             judge;
      logic             emit;
      logic [IDX_W-1:0] emit_idx;
      logic             emit_end;
      logic             advance;
   } hsvrm_cmd_type;

   typedef struct packed {
      logic             div_done;
      logic             row_last;
      logic [CNT_W-1:0] count;
      logic             out_free;
   } hsvrm_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hsvrm_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hsvrm_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           go,
   input  wire logic [hsvrm_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [hsvrm_pkg::DIV_DEN_W-1:0] den,
   output logic      [hsvrm_pkg::DIV_Q_W-1:0]   quo,
   output logic                                 done
);

   localparam int SH_W = hsvrm_pkg::DIV_DEN_W + hsvrm_pkg::DIV_Q_W - 1;

   logic [hsvrm_pkg::DIV_NUM_W-1:0]  rem_ff, rem_in;
   logic [SH_W-1:0]                  dsh_ff, dsh_in;
   logic [hsvrm_pkg::DIV_Q_W-1:0]    quo_ff, quo_in;
   logic [hsvrm_pkg::DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic                             fits;

   assign fits = rem_ff >= hsvrm_pkg::DIV_NUM_W'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in  = num;
         dsh_in  = {den, (hsvrm_pkg::DIV_Q_W - 1)'(0)};
         cnt_in  = hsvrm_pkg::DIV_STEP_W'(hsvrm_pkg::DIV_Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - hsvrm_pkg::DIV_NUM_W'(dsh_ff);
         end
         quo_in = {quo_ff[hsvrm_pkg::DIV_Q_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrm_datapath.sv -----
// Pixel capture, HSV conversion, range test, window buffer and result register.
`timescale 1ns / 1ps
`default_nettype none

module hsvrm_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hsvrm_pkg::hsvrm_cmd_type          cmd,
   output hsvrm_pkg::hsvrm_status_type            status,
   input  wire logic [hsvrm_pkg::PIX_W-1:0]        req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              csr_valid,
   input  wire logic [hsvrm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [hsvrm_pkg::CH_W-1:0]         csr_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [hsvrm_pkg::PIX_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int W  = hsvrm_pkg::WINDOW;
   localparam int CW = hsvrm_pkg::CH_W;
   localparam int NW = hsvrm_pkg::DIV_NUM_W;
   localparam int QW = hsvrm_pkg::DIV_Q_W;

   // range registers
   logic [CW-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff, val_low_ff, val_high_ff;

   // current pixel and its conversion terms
   logic [hsvrm_pkg::PIX_W-1:0]     pix_ff;
   logic                            last_ff;
   logic                            v_zero_ff, d_zero_ff;
   logic [CW-1:0]                   v_ff;
   logic [NW-1:0]                   num_s_ff, num_h_ff;
   logic [hsvrm_pkg::DIV_DEN_W-1:0] den_s_ff, den_h_ff;
   logic [QW-1:0]                   s_ff;

   // window buffer
   logic [hsvrm_pkg::PIX_W-1:0] buf_px_ff [W];
   logic                        buf_sel_ff [W];
   logic [hsvrm_pkg::IDX_W-1:0] fill_ff;

   // result register
   logic                        out_valid_ff;
   logic [hsvrm_pkg::PIX_W-1:0] out_data_ff, out_data_in;
   logic                        out_last_ff;

   logic [CW-1:0] b_c, g_c, r_c, v_c, mn_c, d_c;
   logic [19:0]   hnum_c;
   logic [NW-1:0] snum_c;

   logic [QW-1:0] quo;
   logic          div_done;
   logic [QW-1:0] hue_c;
   logic          sel_c;

   assign b_c = pix_ff[CW-1:0];
   assign g_c = pix_ff[2*CW-1:CW];
   assign r_c = pix_ff[3*CW-1:2*CW];

   // max/min and the offset sector numerator; red wins ties, then green
   always_comb begin
      v_c = r_c;
      if (g_c > v_c) v_c = g_c;
      if (b_c > v_c) v_c = b_c;
      mn_c = r_c;
      if (g_c < mn_c) mn_c = g_c;
      if (b_c < mn_c) mn_c = b_c;
      d_c    = v_c - mn_c;
      snum_c = NW'(d_c) * NW'(510) + NW'(v_c);
      if (v_c == r_c) begin
         hnum_c = 20'(g_c) * 20'd60 - 20'(b_c) * 20'd60 + 20'(d_c) * 20'd361;
      end else if (v_c == g_c) begin
         hnum_c = 20'(b_c) * 20'd60 - 20'(r_c) * 20'd60 + 20'(d_c) * 20'd481;
      end else begin
         hnum_c = 20'(r_c) * 20'd60 - 20'(g_c) * 20'd60 + 20'(d_c) * 20'd601;
      end
   end

   hsvrm_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (cmd.div_go),
      .num   (cmd.div_hue ? num_h_ff : num_s_ff),
      .den   (cmd.div_hue ? den_h_ff : den_s_ff),
      .quo   (quo),
      .done  (div_done)
   );

   // hue wrap and range test
   always_comb begin
      if (d_zero_ff) begin
         hue_c = '0;
      end else if (quo >= hsvrm_pkg::HUE_WRAP) begin
         hue_c = quo - hsvrm_pkg::HUE_WRAP;
      end else begin
         hue_c = quo;
      end
      sel_c = (hue_c >= QW'(hue_low_ff)) && (hue_c <= QW'(hue_high_ff)) &&
              (s_ff >= QW'(sat_low_ff)) && (s_ff <= QW'(sat_high_ff)) &&
              (v_ff >= val_low_ff) && (v_ff <= val_high_ff);
   end

   // window maximum from entry emit_idx up to the newest pending entry
   always_comb begin
      logic [CW-1:0]                m;
      logic [hsvrm_pkg::CNT_W-1:0] n;
      n = hsvrm_pkg::CNT_W'(fill_ff) + hsvrm_pkg::CNT_W'(1);
      for (int k = 0; k < 3; k++) begin
         m = '0;
         for (int i = 0; i < W; i++) begin
            if (hsvrm_pkg::CNT_W'(i) >= hsvrm_pkg::CNT_W'(cmd.emit_idx) &&
                hsvrm_pkg::CNT_W'(i) < n &&
                buf_px_ff[i][k*CW +: CW] > m) begin
               m = buf_px_ff[i][k*CW +: CW];
            end
         end
         out_data_in[k*CW +: CW] = buf_sel_ff[cmd.emit_idx] ? m : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff   <= hsvrm_pkg::HUE_LOW_RST;
         hue_high_ff  <= hsvrm_pkg::HUE_HIGH_RST;
         sat_low_ff   <= hsvrm_pkg::SAT_LOW_RST;
         sat_high_ff  <= hsvrm_pkg::SAT_HIGH_RST;
         val_low_ff   <= hsvrm_pkg::VAL_LOW_RST;
         val_high_ff  <= hsvrm_pkg::VAL_HIGH_RST;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               hsvrm_pkg::REG_HUE_LOW:  hue_low_ff  <= csr_data;
               hsvrm_pkg::REG_HUE_HIGH: hue_high_ff <= csr_data;
               hsvrm_pkg::REG_SAT_LOW:  sat_low_ff  <= csr_data;
               hsvrm_pkg::REG_SAT_HIGH: sat_high_ff <= csr_data;
               hsvrm_pkg::REG_VAL_LOW:  val_low_ff  <= csr_data;
               hsvrm_pkg::REG_VAL_HIGH: val_high_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.advance) begin
            if (last_ff) begin
               fill_ff <= '0;
            end else if (status.count != hsvrm_pkg::CNT_W'(W)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff             <= req_tdata;
         last_ff            <= req_tlast;
         buf_px_ff[fill_ff] <= req_tdata;
      end
      if (cmd.prep) begin
         v_ff      <= v_c;
         v_zero_ff <= (v_c == '0);
         d_zero_ff <= (d_c == '0);
         num_s_ff  <= snum_c;
         den_s_ff  <= {v_c, 1'b0};
         num_h_ff  <= hnum_c[NW-1:0];
         den_h_ff  <= {d_c, 1'b0};
      end
      if (cmd.s_latch) begin
         s_ff <= v_zero_ff ? '0 : quo;
      end
      if (cmd.judge) begin
         buf_sel_ff[fill_ff] <= sel_c;
      end
      // drop the oldest entry once a full window has been reported
      if (cmd.advance && !last_ff && status.count == hsvrm_pkg::CNT_W'(W)) begin
         for (int i = 0; i < W - 1; i++) begin
            buf_px_ff[i]  <= buf_px_ff[i+1];
            buf_sel_ff[i] <= buf_sel_ff[i+1];
         end
      end
      if (cmd.emit) begin
         out_data_ff <= out_data_in;
         out_last_ff <= cmd.emit_end;
      end
   end

   assign status.div_done = div_done;
   assign status.row_last = last_ff;
   assign status.count    = hsvrm_pkg::CNT_W'(fill_ff) + hsvrm_pkg::CNT_W'(1);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrm_ctrl.sv -----
// Sequencer: capture, conversion, two divisions and result issue per request.
`timescale 1ns / 1ps
`default_nettype none

module hsvrm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire hsvrm_pkg::hsvrm_status_type status,
   output hsvrm_pkg::hsvrm_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD_S,
      ST_WAIT_S,
      ST_WAIT_H,
      ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [hsvrm_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [hsvrm_pkg::CNT_W-1:0]  total;
   logic [hsvrm_pkg::CNT_W-1:0]  idx_next;

   // results owed: every pending pixel on a row end, else one per full window
   always_comb begin
      if (status.row_last) begin
         total = status.count;
      end else if (status.count == hsvrm_pkg::CNT_W'(hsvrm_pkg::WINDOW)) begin
         total = hsvrm_pkg::CNT_W'(1);
      end else begin
         total = '0;
      end
   end

   assign idx_next = hsvrm_pkg::CNT_W'(idx_ff) + hsvrm_pkg::CNT_W'(1);

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_tready = 1'b0;
      cmd.emit_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            idx_in     = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LOAD_S;
         end
         ST_LOAD_S: begin
            cmd.div_go = 1'b1;
            state_in   = ST_WAIT_S;
         end
         ST_WAIT_S: begin
            if (status.div_done) begin
               cmd.s_latch = 1'b1;
               cmd.div_go  = 1'b1;
               cmd.div_hue = 1'b1;
               state_in    = ST_WAIT_H;
            end
         end
         ST_WAIT_H: begin
            cmd.div_hue = 1'b1;
            if (status.div_done) begin
               cmd.judge = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (total == '0) begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_end = status.row_last && (idx_next == status.count);
               if (idx_next == total) begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_range_mask_window_max_core.sv -----
// Top level of the HSV range mask with forward window maximum.
`timescale 1ns / 1ps
`default_nettype none

// Takes a raster stream of 8-bit BGR pixels, converts each to 8-bit HSV
// (V = largest channel, S = 255*(V-min)/V, H = sector hue halved to 0..179,
// both divisions rounded to nearest) and selects the pixel when H, S and V
// all sit inside the inclusive bounds held in six configuration registers
// (index 0..5: hue_low, hue_high, sat_low, sat_high, val_low, val_high;
// other indexes are ignored). A selected pixel reports the per-channel
// maximum over itself and the next WINDOW-1 pixels of its row; an
// unselected one reports zero. Results lag by WINDOW-1 pixels and the request
// flagged with req_tlast flushes the whole pending window, the final result
// of the row carrying rsp_tlast. One request is handled at a time and goes
// through capture, conversion set-up, two nine-step runs of the shared
// restoring divider (saturation, then hue) and an issue step that releases
// its results, waiting while the output register is still full.
// Results wait in an output register, so the next request is taken while a
// result is still held by the consumer. Write the bounds only while idle.

module hsv_range_mask_window_max_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: tdata = blue[7:0], green[15:8], red[23:16]; tlast = last_in_row
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [hsvrm_pkg::PIX_W-1:0]        req_tdata,
   input  wire logic                              req_tlast,
   // result: tdata = blue_out[7:0], green_out[15:8], red_out[23:16];
   // tlast = row_end_out
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [hsvrm_pkg::PIX_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [hsvrm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [hsvrm_pkg::CH_W-1:0]         csr_data
);

   hsvrm_pkg::hsvrm_cmd_type    cmd;
   hsvrm_pkg::hsvrm_status_type status;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   // sequence each request through the conversion and window steps
   hsvrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold pixels, bounds and the result register
   hsvrm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- tb/sv/hsv_range_mask_window_max_core_tb.sv -----
// Testbench for the HSV range mask with forward window maximum: directed and random pixel rows.
`timescale 1ns / 1ps

module hsv_range_mask_window_max_core_tb;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 9;
   // Settling time after the last result, so that a request which releases
   // nothing finishes its conversion before the bounds are touched.
   localparam int SETTLE_CYCLES = 48;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;

   // Indexes past the register file: the block must ignore writes to them.
   localparam logic [hsvrm_pkg::CSR_IDX_W-1:0] REG_SPARE_A = hsvrm_pkg::REG_VAL_HIGH + 3'd1;
   localparam logic [hsvrm_pkg::CSR_IDX_W-1:0] REG_SPARE_B = hsvrm_pkg::REG_VAL_HIGH + 3'd2;

   // One pixel, packed so that blue sits in the lowest byte as on tdata.
   typedef struct packed {
      logic [hsvrm_pkg::CH_W-1:0] red;
      logic [hsvrm_pkg::CH_W-1:0] green;
      logic [hsvrm_pkg::CH_W-1:0] blue;
   } bgr_type;

   typedef struct packed {
      bgr_type colour;
      logic    row_end;
   } mask_result_type;

   typedef struct packed {
      logic [hsvrm_pkg::CSR_IDX_W-1:0] index;
      logic [hsvrm_pkg::CH_W-1:0]      data;
   } bound_write_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [hsvrm_pkg::PIX_W-1:0]     req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [hsvrm_pkg::PIX_W-1:0]     rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [hsvrm_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [hsvrm_pkg::CH_W-1:0]      csr_data   = '0;

   // Predictor state: bounds in force, and the pixels still held for their
   // window, the oldest first.
   logic [hsvrm_pkg::CH_W-1:0]       bound [0:5];
   bgr_type [hsvrm_pkg::WINDOW-1:0]  held_pixels;
   logic [hsvrm_pkg::WINDOW-1:0]     held_selected;
   int                               held_count;

   mask_result_type expected_pixels[$];
   bound_write_type csr_writes[$];
   mask_result_type checked_result;

   int fail_count = 0;
   int gap_pct    = 20;
   int stall_pct  = 20;
   int stall_left = 0;

   hsv_range_mask_window_max_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Give up on a hung block long after the slowest legal run would finish.
   initial begin
      #(2_000_000);
      $display("Verification failed");
      $finish;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   function automatic bgr_type rgb(input int r, input int g, input int b);
      bgr_type p;
      p.red   = 8'(r);
      p.green = 8'(g);
      p.blue  = 8'(b);
      return p;
   endfunction

   // Append one expected result behind those already waiting.
   function automatic void expect_result(input bgr_type colour, input bit row_end);
      mask_result_type r;
      r.colour        = colour;
      r.row_end       = row_end;
      expected_pixels = {expected_pixels, r};
   endfunction

   // Queue one register write for the next flush.
   function automatic void queue_write(input logic [hsvrm_pkg::CSR_IDX_W-1:0] index,
                                       input logic [hsvrm_pkg::CH_W-1:0] data);
      bound_write_type w;
      w.index    = index;
      w.data     = data;
      csr_writes = {csr_writes, w};
   endfunction

   // Convert to 8-bit HSV: value is the largest channel, saturation and the
   // halved sector hue both round to nearest with ties going up.
   function automatic void to_hsv(input bgr_type p, output int hue, output int sat,
                                  output int val);
      int lo;
      int span;
      int h;
      val = p.red;
      lo  = p.red;
      if (p.green > val) val = p.green;
      if (p.blue > val) val = p.blue;
      if (p.green < lo) lo = p.green;
      if (p.blue < lo) lo = p.blue;
      span = val - lo;
      sat  = 0;
      hue  = 0;
      if (val != 0) sat = (510 * span + val) / (2 * val);
      if (span != 0) begin
         // Red wins a tie for the largest channel, then green.
         if (val == p.red) h = int'(p.green) - int'(p.blue);
         else if (val == p.green) h = int'(p.blue) - int'(p.red) + 2 * span;
         else h = int'(p.red) - int'(p.green) + 4 * span;
         // Offset by a full turn so the numerator never goes negative.
         hue = (60 * h + 361 * span) / (2 * span);
         if (hue >= 180) hue -= 180;
      end
   endfunction

   // Bounds are compared as written: a lower bound above its upper bound
   // selects nothing.
   function automatic bit colour_selected(input bgr_type p);
      int hue;
      int sat;
      int val;
      to_hsv(p, hue, sat, val);
      return hue >= bound[hsvrm_pkg::REG_HUE_LOW] && hue <= bound[hsvrm_pkg::REG_HUE_HIGH] &&
             sat >= bound[hsvrm_pkg::REG_SAT_LOW] && sat <= bound[hsvrm_pkg::REG_SAT_HIGH] &&
             val >= bound[hsvrm_pkg::REG_VAL_LOW] && val <= bound[hsvrm_pkg::REG_VAL_HIGH];
   endfunction

   // Per-channel maximum from pixel first up to the end of the window, or
   // zero when pixel first was not selected.
   function automatic bgr_type window_peak(input bgr_type [hsvrm_pkg::WINDOW-1:0] win,
                                           input logic [hsvrm_pkg::WINDOW-1:0] sel,
                                           input int first, input int n);
      bgr_type peak;
      peak = '0;
      for (int i = first; i < n; i++) begin
         if (win[i].red > peak.red) peak.red = win[i].red;
         if (win[i].green > peak.green) peak.green = win[i].green;
         if (win[i].blue > peak.blue) peak.blue = win[i].blue;
      end
      if (!sel[first]) peak = '0;
      return peak;
   endfunction

   // Advance the window by one pixel and queue the results it releases.
   function automatic void predict_pixel(input bgr_type p, input bit last);
      bgr_type [hsvrm_pkg::WINDOW-1:0] win;
      logic [hsvrm_pkg::WINDOW-1:0]    sel;
      int                              n;
      win = '0;
      sel = '0;
      n   = held_count;
      for (int i = 0; i < n; i++) begin
         win[i] = held_pixels[i];
         sel[i] = held_selected[i];
      end
      win[n] = p;
      sel[n] = colour_selected(p);
      n++;
      if (last) begin
         // Row end: flush every held pixel, the final one carries the mark.
         for (int i = 0; i < n; i++) begin
            expect_result(window_peak(win, sel, i, n), i == n - 1);
         end
         held_pixels   = '0;
         held_selected = '0;
         held_count    = 0;
      end else if (n == hsvrm_pkg::WINDOW) begin
         expect_result(window_peak(win, sel, 0, n), 1'b0);
         for (int i = 1; i < n; i++) begin
            held_pixels[i-1]   = win[i];
            held_selected[i-1] = sel[i];
         end
         held_count = n - 1;
      end else begin
         for (int i = 0; i < n; i++) begin
            held_pixels[i]   = win[i];
            held_selected[i] = sel[i];
         end
         held_count = n;
      end
   endfunction

   // Offer one request, with an occasional idle burst in front, and record
   // its expected results once it is taken.
   task automatic send_pixel(input bgr_type p, input bit last);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_pixel(p, last);
   endtask

   // Write the queued registers back to back, holding valid throughout.
   task automatic flush_csr_writes();
      bound_write_type w;
      while (csr_writes.size() != 0) begin
         w = csr_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         do @(posedge clock); while (!csr_ready);
         if (w.index <= hsvrm_pkg::REG_VAL_HIGH) bound[w.index] = w.data;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_bounds(input logic [hsvrm_pkg::CH_W-1:0] hue_lo,
                             input logic [hsvrm_pkg::CH_W-1:0] hue_hi,
                             input logic [hsvrm_pkg::CH_W-1:0] sat_lo,
                             input logic [hsvrm_pkg::CH_W-1:0] sat_hi,
                             input logic [hsvrm_pkg::CH_W-1:0] val_lo,
                             input logic [hsvrm_pkg::CH_W-1:0] val_hi);
      queue_write(hsvrm_pkg::REG_HUE_LOW, hue_lo);
      queue_write(hsvrm_pkg::REG_HUE_HIGH, hue_hi);
      queue_write(hsvrm_pkg::REG_SAT_LOW, sat_lo);
      queue_write(hsvrm_pkg::REG_SAT_HIGH, sat_hi);
      queue_write(hsvrm_pkg::REG_VAL_LOW, val_lo);
      queue_write(hsvrm_pkg::REG_VAL_HIGH, val_hi);
      flush_csr_writes();
   endtask

   // Drop valid, wait for every expected result, then let a request that
   // releases nothing finish its conversion before the bounds may change.
   task automatic drain();
      req_tvalid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++) begin
         @(posedge clock);
      end
      if (expected_pixels.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived",
                                expected_pixels.size()));
         expected_pixels.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [hsvrm_pkg::CH_W-1:0] nudge(input logic [hsvrm_pkg::CH_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 48)) - 24;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Mostly pixels close to the anchor, so that the bounds built around it
   // select a fair share; the rest random, grey or saturated to the rails.
   function automatic bgr_type make_pixel(input bgr_type anchor);
      bgr_type p;
      int      pick;
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         p.red   = nudge(anchor.red);
         p.green = nudge(anchor.green);
         p.blue  = nudge(anchor.blue);
      end else if (pick < 13) begin
         p = hsvrm_pkg::PIX_W'($urandom);
      end else if (pick < 15) begin
         p.red   = 8'($urandom);
         p.green = p.red;
         p.blue  = p.red;
      end else if (pick < 17) begin
         p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
         p = anchor;
      end
      return p;
   endfunction

   // Bound pair: usually a window round the centre, sometimes wide open,
   // inverted or arbitrary.
   function automatic void pick_bounds(input int centre,
                                       output logic [hsvrm_pkg::CH_W-1:0] lo,
                                       output logic [hsvrm_pkg::CH_W-1:0] hi);
      int m;
      int a;
      int b;
      case ($urandom_range(0, 9))
         0: begin
            lo = 8'd0;
            hi = 8'd255;
         end
         1: begin
            a  = $urandom_range(1, 255);
            lo = 8'(a);
            hi = 8'($urandom_range(0, a - 1));
         end
         2: begin
            lo = 8'($urandom);
            hi = 8'($urandom);
         end
         default: begin
            m  = $urandom_range(0, 40);
            a  = centre - m;
            b  = centre + m;
            lo = (a < 0) ? 8'd0 : 8'(a);
            hi = (b > 255) ? 8'd255 : 8'(b);
         end
      endcase
   endfunction

   task automatic run_random_phase(input int items, input bit keep_row_open);
      bgr_type                    anchor;
      int                         hue;
      int                         sat;
      int                         val;
      logic [hsvrm_pkg::CH_W-1:0] hl, hh, sl, sh, vl, vh;
      int                         row_left;
      anchor = hsvrm_pkg::PIX_W'($urandom);
      to_hsv(anchor, hue, sat, val);
      pick_bounds(hue, hl, hh);
      pick_bounds(sat, sl, sh);
      pick_bounds(val, vl, vh);
      set_bounds(hl, hh, sl, sh, vl, vh);
      row_left = 0;
      for (int i = 0; i < items; i++) begin
         if (row_left == 0) begin
            row_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
         end
         row_left--;
         send_pixel(make_pixel(anchor), row_left == 0 || (i == items - 1 && !keep_row_open));
      end
      drain();
   endtask

   // Reset bounds (hue 0..10, sat 43..255, val 46..255): pure and near
   // reds, the value and saturation edges, hue wrap and channel ties.
   task automatic test_reset_bounds();
      send_pixel(rgb(255, 0, 0), 1'b1);        // one-pixel row
      send_pixel(rgb(0, 0, 0), 1'b0);
      send_pixel(rgb(255, 255, 255), 1'b0);
      send_pixel(rgb(46, 0, 0), 1'b0);         // value just inside
      send_pixel(rgb(45, 0, 0), 1'b1);         // value just outside
      send_pixel(rgb(255, 20, 0), 1'b0);       // hue wraps round to 2
      send_pixel(rgb(255, 0, 20), 1'b0);       // hue 178, near the top of the circle
      send_pixel(rgb(200, 200, 0), 1'b0);      // red and green tie
      send_pixel(rgb(0, 200, 200), 1'b0);      // green and blue tie
      send_pixel(rgb(200, 0, 200), 1'b1);      // red and blue tie
      send_pixel(rgb(0, 255, 0), 1'b0);
      send_pixel(rgb(0, 0, 255), 1'b0);
      send_pixel(rgb(255, 128, 128), 1'b1);    // saturation lands exactly on 127
      send_pixel(rgb(255, 212, 212), 1'b0);    // saturation just inside
      send_pixel(rgb(255, 213, 213), 1'b1);    // saturation just outside
      drain();
   endtask

   // Wide-open, closed and out-of-range bounds, plus writes to unused indexes.
   task automatic test_bound_extremes();
      set_bounds(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(rgb(0, 0, 0), 1'b0);
      send_pixel(rgb(255, 255, 255), 1'b0);
      send_pixel(rgb(17, 99, 230), 1'b1);
      drain();
      // The unused indexes go out in the same burst as the next bounds.
      queue_write(REG_SPARE_A, 8'hFF);
      queue_write(REG_SPARE_B, 8'h00);
      set_bounds(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
      send_pixel(rgb(255, 0, 0), 1'b0);
      send_pixel(rgb(128, 128, 128), 1'b1);
      drain();
      set_bounds(8'd180, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(rgb(255, 0, 20), 1'b1);
      drain();
      set_bounds(8'd179, 8'd180, 8'd0, 8'd255, 8'd0, 8'd255);
      send_pixel(rgb(255, 0, 20), 1'b1);
      drain();
   endtask

   // Random rows under changing bounds; some phases stop mid-row so held
   // pixels keep the selection they arrived with across a bounds change.
   task automatic test_random_rows();
      for (int phase = 0; phase < 8; phase++) begin
         gap_pct   = (phase % 3 == 0) ? 0 : 30;
         stall_pct = (phase % 4 == 1) ? 0 : 25;
         run_random_phase(50, phase % 2 == 1);
      end
   endtask

   // Finish at full rate on both sides, with no idling at all.
   task automatic test_full_rate();
      gap_pct   = 0;
      stall_pct = 0;
      run_random_phase(60, 1'b0);
   endtask

   // Consumer: drop ready in bursts of random length, none while stall_pct is 0.
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("unexpected result tdata=%h tlast=%b", rsp_tdata, rsp_tlast));
         end else begin
            checked_result = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== checked_result.colour.blue ||
                rsp_tdata[15:8] !== checked_result.colour.green ||
                rsp_tdata[23:16] !== checked_result.colour.red ||
                rsp_tlast !== checked_result.row_end) begin
               note_failure($sformatf(
                  "result mismatch: expected b=%0d g=%0d r=%0d end=%b, got b=%0d g=%0d r=%0d end=%b",
                  checked_result.colour.blue, checked_result.colour.green,
                  checked_result.colour.red, checked_result.row_end,
                  rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast));
            end
         end
      end
   end

   initial begin
      bound[hsvrm_pkg::REG_HUE_LOW]  = hsvrm_pkg::HUE_LOW_RST;
      bound[hsvrm_pkg::REG_HUE_HIGH] = hsvrm_pkg::HUE_HIGH_RST;
      bound[hsvrm_pkg::REG_SAT_LOW]  = hsvrm_pkg::SAT_LOW_RST;
      bound[hsvrm_pkg::REG_SAT_HIGH] = hsvrm_pkg::SAT_HIGH_RST;
      bound[hsvrm_pkg::REG_VAL_LOW]  = hsvrm_pkg::VAL_LOW_RST;
      bound[hsvrm_pkg::REG_VAL_HIGH] = hsvrm_pkg::VAL_HIGH_RST;
      held_pixels   = '0;
      held_selected = '0;
      held_count    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_bounds();
      test_bound_extremes();
      test_random_rows();
      test_full_rate();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
